### src/sicu_pkg.sv
// Shared types and constants for the sequence interleave check unit.
// No dependencies; used by the controller, datapath, top level and checker.
`default_nettype none

package sicu_pkg;

  localparam int MAX_LEN_DEF = 1024;

  localparam int OP_W       = 2;
  localparam int POS_W      = 11;
  localparam int ELEM_W     = 16;
  localparam int LEN_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_LOAD_MERGED = 2'd2,
    OP_EVALUATE    = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LENGTH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_en;  // store write for an accepted load transfer
    logic row_rd;   // issue row setup reads (first[x-1], merged[x-1])
    logic row_ld;   // setup data back: latch column zero and row element
    logic cell_rd;  // issue reads for cell (x, y)
  } cmd_t;

endpackage

`default_nettype wire

### src/sicu_ctrl.sv
// Controller for the sequence interleave check unit: handshake, length
// registers, table sweep sequencer and result register. Uses sicu_pkg.
`default_nettype none

module sicu_ctrl #(
  parameter int MAX_LEN = sicu_pkg::MAX_LEN_DEF,
  localparam int CNT_W = $clog2(MAX_LEN + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sicu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sicu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sicu_pkg::OP_W-1:0]       in_operation,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_possible,
  output sicu_pkg::cmd_t                       cmd,
  output logic [CNT_W-1:0]                     x,
  output logic [CNT_W-1:0]                     y,
  input  wire logic                            result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_CELL,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                      state_r, state_nxt;
  logic [sicu_pkg::LEN_W-1:0]  first_len_r, first_len_nxt;
  logic [sicu_pkg::LEN_W-1:0]  second_len_r, second_len_nxt;
  logic [CNT_W-1:0]            n1_r, n1_nxt;
  logic [CNT_W-1:0]            n2_r, n2_nxt;
  logic [CNT_W-1:0]            x_r, x_nxt;
  logic [CNT_W-1:0]            y_r, y_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_possible_r, out_possible_nxt;

  logic        accept;
  logic        is_eval;
  logic [31:0] first_len32;
  logic [31:0] second_len32;
  logic [CNT_W-1:0] n1_clamp;
  logic [CNT_W-1:0] n2_clamp;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_eval  = (sicu_pkg::op_t'(in_operation) == sicu_pkg::OP_EVALUATE);

  // lengths above the store depth saturate
  assign first_len32  = 32'(first_len_r);
  assign second_len32 = 32'(second_len_r);
  assign n1_clamp = (first_len32 > 32'(MAX_LEN)) ? CNT_W'(MAX_LEN) : CNT_W'(first_len32);
  assign n2_clamp = (second_len32 > 32'(MAX_LEN)) ? CNT_W'(MAX_LEN) : CNT_W'(second_len32);

  always_comb begin
    cmd.load_en = accept && !is_eval;
    cmd.row_rd  = (state_r == ST_ROW_RD);
    cmd.row_ld  = (state_r == ST_ROW_LD);
    cmd.cell_rd = (state_r == ST_CELL);
  end

  always_comb begin
    state_nxt        = state_r;
    first_len_nxt    = first_len_r;
    second_len_nxt   = second_len_r;
    n1_nxt           = n1_r;
    n2_nxt           = n2_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_possible_nxt = out_possible_r;

    if (cfg_we) begin
      if (cfg_index == sicu_pkg::CFG_FIRST_LENGTH) begin
        first_len_nxt = cfg_data;
      end else if (cfg_index == sicu_pkg::CFG_SECOND_LENGTH) begin
        second_len_nxt = cfg_data;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && is_eval) begin
          n1_nxt    = n1_clamp;
          n2_nxt    = n2_clamp;
          x_nxt     = '0;
          state_nxt = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        state_nxt = ST_ROW_LD;
      end
      ST_ROW_LD: begin
        if (n2_r == '0) begin
          if (x_r == n1_r) begin
            state_nxt = ST_FINISH;
          end else begin
            x_nxt     = x_r + CNT_W'(1);
            state_nxt = ST_ROW_RD;
          end
        end else begin
          y_nxt     = CNT_W'(1);
          state_nxt = ST_CELL;
        end
      end
      ST_CELL: begin
        if (y_r == n2_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          y_nxt = y_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (x_r == n1_r) begin
          state_nxt = ST_FINISH;
        end else begin
          x_nxt     = x_r + CNT_W'(1);
          state_nxt = ST_ROW_RD;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_possible_nxt = result;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      first_len_r  <= '0;
      second_len_r <= '0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      first_len_r    <= first_len_nxt;
      second_len_r   <= second_len_nxt;
      n1_r           <= n1_nxt;
      n2_r           <= n2_nxt;
      x_r            <= x_nxt;
      y_r            <= y_nxt;
      out_possible_r <= out_possible_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_possible = out_possible_r;
  assign x            = x_r;
  assign y            = y_r;

endmodule

`default_nettype wire

### src/sicu_dpath.sv
// Datapath for the sequence interleave check unit: element stores, one-bit
// row buffer and the cell update. Uses sicu_pkg; driven by sicu_ctrl.
`default_nettype none

module sicu_dpath #(
  parameter int MAX_LEN = sicu_pkg::MAX_LEN_DEF,
  localparam int CNT_W = $clog2(MAX_LEN + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sicu_pkg::cmd_t              cmd,
  input  wire logic [CNT_W-1:0]            x,
  input  wire logic [CNT_W-1:0]            y,
  input  wire logic [sicu_pkg::OP_W-1:0]   in_operation,
  input  wire logic [sicu_pkg::POS_W-1:0]  in_position,
  input  wire logic [sicu_pkg::ELEM_W-1:0] in_element,
  output logic                             result
);

  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int MRG_DEPTH = 2 * MAX_LEN;
  localparam int MRG_W     = $clog2(MRG_DEPTH);
  localparam int SUM_W     = CNT_W + 1;

  logic [sicu_pkg::ELEM_W-1:0] first_mem  [MAX_LEN];
  logic [sicu_pkg::ELEM_W-1:0] second_mem [MAX_LEN];
  logic [sicu_pkg::ELEM_W-1:0] merged_mem [MRG_DEPTH];
  logic                        row_mem    [MAX_LEN];

  logic [sicu_pkg::ELEM_W-1:0] first_q_r;
  logic [sicu_pkg::ELEM_W-1:0] second_q_r;
  logic [sicu_pkg::ELEM_W-1:0] merged_q_r;
  logic                        row_q_r;

  logic [sicu_pkg::ELEM_W-1:0] a_r;       // first[x-1] for the current row
  logic                        col0_r;    // reach at column zero
  logic                        left_r;    // last value written in this row
  logic                        cell_vld_r;
  logic [IDX_W-1:0]            row_wr_idx_r;

  logic [31:0]      pos32;
  logic             first_we, second_we, merged_we;
  logic [CNT_W-1:0] xm1, ym1, yy;
  logic [SUM_W-1:0] mrg_sum;
  logic [IDX_W-1:0] first_rd_idx, cell_idx;
  logic [MRG_W-1:0] mrg_rd_idx;
  logic             top_row;
  logic             col0_new;
  logic             cell_new;

  // load decode; positions past a store are dropped
  assign pos32     = 32'(in_position);
  assign first_we  = cmd.load_en && pos32 < 32'(MAX_LEN) &&
                     (sicu_pkg::op_t'(in_operation) == sicu_pkg::OP_LOAD_FIRST);
  assign second_we = cmd.load_en && pos32 < 32'(MAX_LEN) &&
                     (sicu_pkg::op_t'(in_operation) == sicu_pkg::OP_LOAD_SECOND);
  assign merged_we = cmd.load_en && pos32 < 32'(MRG_DEPTH) &&
                     (sicu_pkg::op_t'(in_operation) == sicu_pkg::OP_LOAD_MERGED);

  // read addresses: row setup uses x-1, a cell uses y-1 and x+y-1
  assign xm1          = x - CNT_W'(1);
  assign ym1          = y - CNT_W'(1);
  assign yy           = cmd.cell_rd ? y : '0;
  assign mrg_sum      = SUM_W'(x) + SUM_W'(yy) - SUM_W'(1);
  assign first_rd_idx = xm1[IDX_W-1:0];
  assign cell_idx     = ym1[IDX_W-1:0];
  assign mrg_rd_idx   = mrg_sum[MRG_W-1:0];

  // first[x-1] is fetched once per row, in the setup read cycle
  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[pos32[IDX_W-1:0]] <= in_element;
    end
    if (cmd.row_rd) begin
      first_q_r <= first_mem[first_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (second_we) begin
      second_mem[pos32[IDX_W-1:0]] <= in_element;
    end
    second_q_r <= second_mem[cell_idx];
  end

  always_ff @(posedge clk) begin
    if (merged_we) begin
      merged_mem[pos32[MRG_W-1:0]] <= in_element;
    end
    merged_q_r <= merged_mem[mrg_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cell_vld_r) begin
      row_mem[row_wr_idx_r] <= cell_new;
    end
    row_q_r <= row_mem[cell_idx];
  end

  // row x = 0 has nothing above; its column zero is the start cell
  assign top_row  = (x == '0);
  assign col0_new = top_row || (col0_r && (first_q_r == merged_q_r));
  assign cell_new = (!top_row && row_q_r && (a_r == merged_q_r)) ||
                    (left_r && (second_q_r == merged_q_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_vld_r <= 1'b0;
    end else begin
      cell_vld_r <= cmd.cell_rd;
    end
  end

  always_ff @(posedge clk) begin
    row_wr_idx_r <= cell_idx;
    if (cmd.row_ld) begin
      col0_r <= col0_new;
      left_r <= col0_new;
      a_r    <= first_q_r;
    end else if (cell_vld_r) begin
      left_r <= cell_new;
    end
  end

  assign result = left_r;

endmodule

`default_nettype wire

### src/sequence_interleave_check_unit.sv
// Evaluate: each of the (n1+1) rows has a setup read and latch, then a cell sweep
// and drain when n2 > 0, then the result is posted; n1, n2 are the lengths
// clamped to MAX_LEN. Throughput: one load transfer per cycle while idle; inputs
// stall in an evaluate; the sweep bound by one read port per store and row buffer.
// Reset (rst_n low, synchronous): controller idle, output empty, lengths zero.
// Stores and row buffer have no reset; no clearing pass is needed.
`default_nettype none

module sequence_interleave_check_unit #(
  parameter int MAX_LEN = sicu_pkg::MAX_LEN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration: index 0 first_length, index 1 second_length
  input  wire logic                            cfg_we,
  input  wire logic [sicu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sicu_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items: loads and evaluate
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sicu_pkg::OP_W-1:0]       in_operation,
  input  wire logic [sicu_pkg::POS_W-1:0]      in_position,
  input  wire logic [sicu_pkg::ELEM_W-1:0]     in_element,
  // results: one per evaluate
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_possible
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  sicu_pkg::cmd_t   cmd;
  logic [CNT_W-1:0] x;
  logic [CNT_W-1:0] y;
  logic             result;

  // Controller: accepts transfers, sequences the table sweep row by row
  // (setup read, setup latch, one cell per cycle, drain) and holds the
  // output register so loads keep flowing while a result waits.
  sicu_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_possible (out_possible),
    .cmd          (cmd),
    .x            (x),
    .y            (y),
    .result       (result)
  );

  // Datapath: element stores, registered reads, one-bit row buffer.
  // Each cell reads the previous row's bit and uses the registered left
  // neighbor value.
  sicu_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .x            (x),
    .y            (y),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_element   (in_element),
    .result       (result)
  );

endmodule

`default_nettype wire

### src/sicu_checker.sv
// Port-level assertions for the sequence interleave check unit, bound to
// the top level. Uses sicu_pkg.
`default_nettype none

module sicu_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic [sicu_pkg::OP_W-1:0]       in_operation,
  input wire logic [sicu_pkg::POS_W-1:0]      in_position,
  input wire logic [sicu_pkg::ELEM_W-1:0]     in_element,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            out_possible
);

  // a stalled input transfer is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable({in_operation, in_position, in_element}))
    else $error("stalled input transfer changed or dropped");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_possible))
    else $error("stalled result changed or dropped");

  // an evaluate transfer makes the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == sicu_pkg::OP_EVALUATE) |=> in_stall)
    else $error("evaluate accepted without going busy");

  // a new result only appears at the end of an evaluation
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result posted while idle");

  // leaving busy always posts a result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("evaluation ended without a result");

endmodule

bind sequence_interleave_check_unit sicu_checker u_sicu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_operation (in_operation),
  .in_position  (in_position),
  .in_element   (in_element),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_possible (out_possible)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sequence_interleave_check_unit: directed script, then random
// load/evaluate sequences scored against an in-bench reachability predictor. Needs sicu_pkg.

module tb_top;

  localparam int MAX_LEN        = sicu_pkg::MAX_LEN_DEF;
  localparam int CLK_HALF       = 6;          // 12 ns period
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE         = 4;          // load write-back margin before a register write
  localparam int HOLD_CYCLES    = 400;        // long receiver hold-off
  localparam int RANDOM_ITEMS   = 360;
  localparam int RANDOM_RESULTS = 24;
  localparam int DRAIN_LIMIT    = 50000;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int NO_TYPED       = -1;         // no typed answer: predictor decides

  typedef struct {
    sicu_pkg::op_t  op;
    logic [10:0]    pos;
    logic [15:0]    value;
  } xfer_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // one script row: an input transfer, or a register write (num holds the length)
  typedef struct {
    row_kind_t                        kind;
    logic [sicu_pkg::CFG_IDX_W-1:0]   cfg_sel;
    sicu_pkg::op_t                    op;
    logic [10:0]                      num;
    logic [15:0]                      value;
    int                               want;
  } row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            cfg_we       = 1'b0;
  logic [sicu_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [sicu_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  logic [sicu_pkg::OP_W-1:0]       in_operation = '0;
  logic [sicu_pkg::POS_W-1:0]      in_position  = '0;
  logic [sicu_pkg::ELEM_W-1:0]     in_element   = '0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  logic                            out_possible;

  sequence_interleave_check_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_element   (in_element),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_possible (out_possible)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow state: stores, written flags (so no evaluate touches a blank entry),
  // and the two length registers as last written.
  // ---------------------------------------------------------------------------
  logic [15:0]  first_seq  [MAX_LEN];
  logic [15:0]  second_seq [MAX_LEN];
  logic [15:0]  merged_seq [2*MAX_LEN];
  bit           first_set  [MAX_LEN];
  bit           second_set [MAX_LEN];
  bit           merged_set [2*MAX_LEN];
  logic [10:0]  len_first  = '0;
  logic [10:0]  len_second = '0;

  bit           possible_due [$];   // expected possible bits, oldest first

  int           mismatches   = 0;
  int           transfers    = 0;
  int           live_items   = 0;   // transfers that are not dropped loads
  int           evals_sent   = 0;
  int           results_seen = 0;
  int           seen_ones    = 0;
  int           cfg_writes   = 0;

  // sender pacing
  bit           gaps_on    = 1'b0;
  int           burst_left = 0;

  // receiver pacing; hold_asked is bumped by the stimulus to request a hold
  int unsigned  hold_asked = 0;
  int unsigned  hold_taken = 0;
  int           hold_left  = 0;
  int           mode_left  = 0;
  int           stall_mode = 0;
  int unsigned  tick       = 0;

  // ---------------------------------------------------------------------------
  // Predictor: one-bit row sweep over the (n1+1) x (n2+1) reachability grid.
  // Lengths above the store size saturate; grid edges have no outside neighbor.
  // ---------------------------------------------------------------------------
  function automatic bit predict_interleave();
    int          n1, n2, x, y;
    bit          reach [MAX_LEN+1];
    logic [15:0] head, m;
    n1 = (len_first  > MAX_LEN) ? MAX_LEN : int'(len_first);
    n2 = (len_second > MAX_LEN) ? MAX_LEN : int'(len_second);
    reach[0] = 1'b1;
    for (y = 1; y <= n2; y++)
      reach[y] = reach[y-1] && (second_seq[y-1] == merged_seq[y-1]);
    for (x = 1; x <= n1; x++) begin
      head     = first_seq[x-1];
      reach[0] = reach[0] && (head == merged_seq[x-1]);
      for (y = 1; y <= n2; y++) begin
        m        = merged_seq[x+y-1];
        reach[y] = (reach[y] && head == m) || (reach[y-1] && second_seq[y-1] == m);
      end
    end
    return reach[n2];
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // bookkeeping for one accepted input transfer
  task automatic commit_transfer(input xfer_t it, input int want);
    transfers++;
    case (it.op)
      sicu_pkg::OP_LOAD_FIRST: if (it.pos < MAX_LEN) begin
        first_seq[it.pos] = it.value;
        first_set[it.pos] = 1'b1;
        live_items++;
      end
      sicu_pkg::OP_LOAD_SECOND: if (it.pos < MAX_LEN) begin
        second_seq[it.pos] = it.value;
        second_set[it.pos] = 1'b1;
        live_items++;
      end
      sicu_pkg::OP_LOAD_MERGED: begin
        merged_seq[it.pos] = it.value;   // merged store spans the whole position range
        merged_set[it.pos] = 1'b1;
        live_items++;
      end
      sicu_pkg::OP_EVALUATE: begin
        possible_due.insert(possible_due.size(),
                            (want == NO_TYPED) ? predict_interleave() : want[0]);
        evals_sent++;
        live_items++;
      end
      default: begin
      end
    endcase
  endtask

  // Offer one item and hold it until the transfer happens. Called just after a
  // rising edge; valid stays high into the next item unless a gap is taken.
  task automatic send_item(input xfer_t it, input int want);
    in_valid     <= 1'b1;
    in_operation <= it.op;
    in_position  <= it.pos;
    in_element   <= it.value;
    do @(posedge clk); while (in_stall);
    commit_transfer(it, want);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering and wait until every expected result is back, then let any
  // trailing store write finish (loads give nothing to wait on).
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (possible_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sicu_pkg::CFG_IDX_W-1:0] sel, input logic [10:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == sicu_pkg::CFG_FIRST_LENGTH) len_first = len;
    else                                   len_second = len;
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic xfer_t noise_item();
    xfer_t it;
    it.op    = sicu_pkg::op_t'($urandom_range(0, 2));
    it.pos   = 11'($urandom);
    it.value = 16'($urandom);
    return it;
  endfunction

  function automatic xfer_t eval_item();
    xfer_t it;
    it.op    = sicu_pkg::OP_EVALUATE;
    it.pos   = 11'($urandom);   // ignored by evaluate, toggled anyway
    it.value = 16'($urandom);
    return it;
  endfunction

  // One well-formed case: set lengths if needed, build two sources over a narrow
  // alphabet, merge them in random order, maybe break the merge, load whatever
  // differs from the stores (with stray loads mixed in), then evaluate.
  task automatic run_case(input int n1_raw, input int n2_raw, input logic [15:0] base,
                          input int span, input int noise_pct, input int mutate_pct);
    int          n1, n2, total, i, j, k, pick;
    logic [15:0] src_a [$];
    logic [15:0] src_b [$];
    logic [15:0] mix   [$];
    logic [15:0] hold;
    xfer_t       plan  [$];
    xfer_t       tmp;
    n1    = (n1_raw > MAX_LEN) ? MAX_LEN : n1_raw;
    n2    = (n2_raw > MAX_LEN) ? MAX_LEN : n2_raw;
    total = n1 + n2;
    if (n1_raw != len_first || n2_raw != len_second) begin
      wait_idle();
      if (n1_raw != len_first)  cfg_write(sicu_pkg::CFG_FIRST_LENGTH, 11'(n1_raw));
      if (n2_raw != len_second) cfg_write(sicu_pkg::CFG_SECOND_LENGTH, 11'(n2_raw));
    end
    for (k = 0; k < n1; k++) src_a.insert(src_a.size(), base + 16'($urandom_range(0, span)));
    for (k = 0; k < n2; k++) src_b.insert(src_b.size(), base + 16'($urandom_range(0, span)));
    i = 0;
    j = 0;
    for (k = 0; k < total; k++) begin
      if (j == n2 || (i < n1 && $urandom_range(0, 1) == 1)) begin
        mix.insert(mix.size(), src_a[i]);
        i++;
      end else begin
        mix.insert(mix.size(), src_b[j]);
        j++;
      end
    end
    // broken merge: swap a neighbor pair or bump one element
    if (total > 0 && $urandom_range(1, 100) <= mutate_pct) begin
      k = $urandom_range(0, total - 1);
      if (k + 1 < total && $urandom_range(0, 1) == 1) begin
        hold     = mix[k];
        mix[k]   = mix[k+1];
        mix[k+1] = hold;
      end else begin
        mix[k] = mix[k] + 16'(1 + $urandom_range(0, span));
      end
    end
    for (k = 0; k < n1; k++)
      if (!first_set[k] || first_seq[k] != src_a[k])
        plan.insert(plan.size(), '{sicu_pkg::OP_LOAD_FIRST, 11'(k), src_a[k]});
    for (k = 0; k < n2; k++)
      if (!second_set[k] || second_seq[k] != src_b[k])
        plan.insert(plan.size(), '{sicu_pkg::OP_LOAD_SECOND, 11'(k), src_b[k]});
    for (k = 0; k < total; k++)
      if (!merged_set[k] || merged_seq[k] != mix[k])
        plan.insert(plan.size(), '{sicu_pkg::OP_LOAD_MERGED, 11'(k), mix[k]});
    pick = plan.size() + 2;
    for (k = 0; k < pick; k++)
      if ($urandom_range(1, 100) <= noise_pct) plan.insert(plan.size(), noise_item());
    for (k = plan.size() - 1; k > 0; k--) begin
      pick       = $urandom_range(0, k);
      tmp        = plan[k];
      plan[k]    = plan[pick];
      plan[pick] = tmp;
    end
    foreach (plan[p]) send_item(plan[p], NO_TYPED);
    send_item(eval_item(), NO_TYPED);
    if ($urandom_range(0, 3) == 0) send_item(eval_item(), NO_TYPED);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern is redrawn whenever its mode counter runs out; a requested
  // hold keeps stall high until the hold counter, loaded from HOLD_CYCLES, runs out.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tick <= tick + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;                          // free-running stretch
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);   // heavy back-pressure
        default: out_stall <= (tick % 5 < 2);                // fixed duty
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transfer must match the oldest expectation.
  // ---------------------------------------------------------------------------
  bit want_bit;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_possible === 1'b1) seen_ones++;
      if (possible_due.size() == 0) begin
        flag_mismatch("result with nothing pending", int'(out_possible), NO_TYPED);
      end else begin
        want_bit = possible_due.pop_front();
        if (out_possible !== want_bit)
          flag_mismatch("possible", int'(out_possible), int'(want_bit));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed script: reset state, store edges, dropped loads, a two-element
  // merge, a broken merge. Typed answers only where obvious.
  // ---------------------------------------------------------------------------
  row_t script [26] = '{
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_EVALUATE,
      11'h000, 16'h0000, 1},  // empty merge
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_FIRST,
      11'h000, 16'hFFFF, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_MERGED,
      11'h000, 16'hFFFF, NO_TYPED},
    '{ROW_CFG,  sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_FIRST,
      11'd1,   16'h0000, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_EVALUATE,
      11'h7FF, 16'hFFFF, 1},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_FIRST,
      11'h7FF, 16'h0000, NO_TYPED},  // dropped
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_FIRST,
      11'h400, 16'h0000, NO_TYPED},  // dropped
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_SECOND,
      11'h400, 16'h0000, NO_TYPED},  // dropped
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_EVALUATE,
      11'h000, 16'h0000, 1},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_MERGED,
      11'h000, 16'h0000, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_EVALUATE,
      11'h000, 16'h0000, 0},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_SECOND,
      11'h000, 16'h0000, NO_TYPED},
    '{ROW_CFG,  sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_FIRST,
      11'd0,   16'h0000, NO_TYPED},
    '{ROW_CFG,  sicu_pkg::CFG_SECOND_LENGTH, sicu_pkg::OP_LOAD_FIRST,
      11'd1,   16'h0000, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_EVALUATE,
      11'h000, 16'h0000, 1},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_MERGED,
      11'h001, 16'hFFFF, NO_TYPED},
    '{ROW_CFG,  sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_FIRST,
      11'd1,   16'h0000, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_EVALUATE,
      11'h2AA, 16'h5555, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_MERGED,
      11'h7FF, 16'hA5A5, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_SECOND,
      11'h3FF, 16'h5A5A, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_FIRST,
      11'h3FF, 16'h8001, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_MERGED,
      11'h001, 16'h0000, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_EVALUATE,
      11'h000, 16'h0000, 0},  // FFFF missing
    '{ROW_CFG,  sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_LOAD_FIRST,
      11'd0,   16'h0000, NO_TYPED},
    '{ROW_CFG,  sicu_pkg::CFG_SECOND_LENGTH, sicu_pkg::OP_LOAD_FIRST,
      11'd0,   16'h0000, NO_TYPED},
    '{ROW_ITEM, sicu_pkg::CFG_FIRST_LENGTH,  sicu_pkg::OP_EVALUATE,
      11'h7FF, 16'hFFFF, 1}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int    k, n1, n2, live_mark, result_mark;
    bit    hold_done;
    xfer_t it;
    hold_done = 1'b0;
    n1        = 0;
    n2        = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script
    gaps_on = ($urandom_range(0, 1) == 1);
    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(script[r].cfg_sel, script[r].num);
      end else begin
        it = '{script[r].op, script[r].num, script[r].value};
        send_item(it, script[r].want);
      end
    end

    // longer sequences: a single column, a single row, a mixed rectangle, a square
    gaps_on = 1'b1;
    run_case(24, 0,  16'h0007, 0, 0, 0);
    run_case(24, 0,  16'h0007, 0, 0, 100);
    gaps_on = 1'b0;
    run_case(0,  24, 16'h0007, 0, 0, 0);
    run_case(20, 4,  16'h0007, 0, 0, 50);
    run_case(16, 16, 16'h0100, 3, 0, 0);

    // random cases, mostly small, lengths kept about half the time
    live_mark   = live_items;
    result_mark = results_seen;
    while (live_items - live_mark < RANDOM_ITEMS || results_seen - result_mark < RANDOM_RESULTS)
    begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) begin
        n1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 6);
        n2 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 6);
      end
      run_case(n1, n2, 16'($urandom), $urandom_range(0, 3), 15, 40);

      // once: long receiver hold while evaluates keep coming, so the block
      // backs up into its input; then a full drain before going on
      if (!hold_done && live_items - live_mark > RANDOM_ITEMS / 2) begin
        hold_done = 1'b1;
        gaps_on   = 1'b0;
        hold_asked++;
        for (k = 0; k < 9; k++)
          send_item((k % 3 == 2) ? noise_item() : eval_item(), NO_TYPED);
        wait_idle();
      end
    end

    // drain with a bound, then watch for strays
    in_valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && possible_due.size() != 0; k++) @(posedge clk);
    while (possible_due.size() != 0) begin
      want_bit = possible_due.pop_front();
      flag_mismatch("result never arrived", NO_TYPED, int'(want_bit));
    end
    repeat (SETTLE * 8) @(posedge clk);

    $display("Ran %0d input transfers (%0d evaluates), %0d register writes.",
             transfers, evals_sent, cfg_writes);
    $display("Checked %0d results: %0d interleavings found, %0d rejected.",
             results_seen, seen_ones, results_seen - seen_ones);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
